// File: design/cce_pkg.sv
// Shared types and constants for the cycle counter extension block.
package cce_pkg;

	// Field and datapath widths
	localparam int CountWidth = 32;
	localparam int TotalWidth = 64;
	localparam int DivWidth   = 13;

	// Depth of the queue between front and back
	localparam int QueueDepth = 2;

	// Item opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Divisor used when the register holds zero
	localparam logic [DivWidth-1:0] DivOne = DivWidth'(1);

	// Read request that travels from the front to the back
	typedef struct packed {
		logic                  valid;
		logic [TotalWidth-1:0] total;
	} rd_req_t;

endpackage

// File: design/cce_front.sv
// Front part: takes samples, tracks wraps and forms the extended total for reads.
module cce_front #(
	parameter int COUNTER_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            op,
	input  logic [cce_pkg::CountWidth-1:0]  cycle_count,
	output cce_pkg::rd_req_t                req
);

	localparam logic [cce_pkg::CountWidth-1:0] SampleMask =
		cce_pkg::CountWidth'((64'd1 << COUNTER_BITS) - 64'd1);

	logic [cce_pkg::CountWidth-1:0] wrap_q;
	logic [cce_pkg::CountWidth-1:0] prev_q;
	logic [cce_pkg::CountWidth-1:0] sample;
	logic [cce_pkg::CountWidth-1:0] wrap_next;
	logic                           is_wrap;

	// Mask the sample and detect a wrap against the previous one
	always_comb begin
		sample    = cycle_count & SampleMask;
		is_wrap   = sample < prev_q;
		wrap_next = wrap_q + {{(cce_pkg::CountWidth-1){1'b0}}, is_wrap};
	end

	// Hold the wrap count and the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= '0;
			prev_q <= '0;
		end else if (accept) begin
			wrap_q <= wrap_next;
			prev_q <= sample;
		end
	end

	// Hand a read to the queue with the updated total
	always_comb begin
		req.valid = accept && (op == cce_pkg::OP_READ);
		req.total = (cce_pkg::TotalWidth'(wrap_next) << COUNTER_BITS)
			| cce_pkg::TotalWidth'(sample);
	end

endmodule

// File: design/cce_queue.sv
// Short queue of read requests between the front and the back.
module cce_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cce_pkg::rd_req_t      wr_req,
	input  logic                  rd_pop,
	output logic                  full,
	output cce_pkg::rd_req_t      rd_req
);

	localparam int PtrWidth = $clog2(cce_pkg::QueueDepth);
	localparam int CntWidth = $clog2(cce_pkg::QueueDepth + 1);

	logic [cce_pkg::TotalWidth-1:0] mem_q [cce_pkg::QueueDepth];
	logic [PtrWidth-1:0]            wr_ptr_q;
	logic [PtrWidth-1:0]            rd_ptr_q;
	logic [CntWidth-1:0]            cnt_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full         = cnt_q == CntWidth'(cce_pkg::QueueDepth);
	assign rd_req.valid = cnt_q != '0;
	assign rd_req.total = mem_q[rd_ptr_q];
	assign do_wr        = wr_req.valid && !full;
	assign do_rd        = rd_pop && rd_req.valid;

	// Store a word at the write pointer
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_req.total;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrWidth'(cce_pkg::QueueDepth - 1))
					? '0 : wr_ptr_q + PtrWidth'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrWidth'(cce_pkg::QueueDepth - 1))
					? '0 : rd_ptr_q + PtrWidth'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CntWidth'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CntWidth'(1);
			end
		end
	end

endmodule

// File: design/cce_back.sv
// Back part: divides the extended total by cycles/us, one bit a cycle unless a waiting result stalls.
module cce_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr,
	input  logic [cce_pkg::DivWidth-1:0]    cfg_data,
	input  cce_pkg::rd_req_t                req,
	output logic                            req_pop,
	input  logic                            pop,
	output logic                            empty,
	output logic [cce_pkg::TotalWidth-1:0]  time_us
);

	localparam int StepWidth = $clog2(cce_pkg::TotalWidth);

	logic [cce_pkg::DivWidth-1:0]   cpu_q;
	logic [cce_pkg::DivWidth-1:0]   div_q;
	logic [cce_pkg::DivWidth-1:0]   rem_q;
	logic [cce_pkg::TotalWidth-1:0] quo_q;
	logic [StepWidth-1:0]           cnt_q;
	logic                           busy_q;
	logic                           res_valid_q;
	logic [cce_pkg::TotalWidth-1:0] res_q;
	logic                           last;
	logic                           step_en;
	logic                           pop_fire;
	logic [cce_pkg::DivWidth:0]     trial;
	logic                           fits;
	logic [cce_pkg::DivWidth-1:0]   rem_next;

	// Hold the divisor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q <= cce_pkg::DivOne;
		end else if (cfg_wr) begin
			cpu_q <= cfg_data;
		end
	end

	assign last     = cnt_q == StepWidth'(cce_pkg::TotalWidth - 1);
	assign pop_fire = pop && res_valid_q;
	assign step_en  = busy_q && !(last && res_valid_q && !pop_fire);
	assign req_pop  = !busy_q && req.valid;
	assign empty    = !res_valid_q;
	assign time_us  = res_q;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial    = {rem_q, quo_q[cce_pkg::TotalWidth-1]};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? cce_pkg::DivWidth'(trial - {1'b0, div_q})
			: cce_pkg::DivWidth'(trial);
	end

	// Run the division sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req_pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (step_en) begin
			busy_q <= !last;
			cnt_q  <= last ? '0 : cnt_q + StepWidth'(1);
		end
	end

	// Load operands, then advance remainder and quotient
	always_ff @(posedge clk) begin
		if (req_pop) begin
			quo_q <= req.total;
			rem_q <= '0;
			div_q <= (cpu_q == '0) ? cce_pkg::DivOne : cpu_q;
		end else if (step_en) begin
			quo_q <= {quo_q[cce_pkg::TotalWidth-2:0], fits};
			rem_q <= rem_next;
		end
	end

	// Hold the finished word until it is popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (res_valid_q && !pop_fire) || (step_en && last);
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && last) begin
			res_q <= {quo_q[cce_pkg::TotalWidth-2:0], fits};
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> div_q != '0)
		else $error("divisor zero during division");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < div_q)
		else $error("remainder not below divisor");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0)
		else $error("step count left nonzero while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !pop) |=> res_valid_q && $stable(res_q))
		else $error("waiting result lost or changed");

endmodule

// File: design/cycle_counter_extend_to_us_top.sv
// Top level of the cycle counter extension to a microsecond time base.
//
// Usage:
//   Input queue side: drive op and cycle_count and raise push; the word is
//   taken at an edge where full is low. op 0 only updates the wrap tracking,
//   op 1 also asks for the time in microseconds.
//   Result queue side: while empty is low, time_us holds the oldest answer;
//   pulse pop to take it.
//   Config: cfg_data carries cycles_per_us, written when cfg_valid is high
//   (cfg_ready is always high). Write it only while the block is idle.
// Flow:
//   Sample words are taken one per cycle while the request queue has room.
//   A read word is written into the request queue, loaded from it into the
//   divider, then runs through the shift-subtract divider, one bit per
//   cycle unless a waiting result stalls its last step. The divider takes a
//   new read only once it is idle, so it is the limit on reads.
// Reset drops all queued requests, clears the wrap count and the last
// sample to zero and sets cycles_per_us to 1. When the receiver does not
// pop, the divider holds its last step, the two-word request queue fills
// and then full rises.
module cycle_counter_extend_to_us_top #(
	parameter int COUNTER_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            op,
	input  logic [cce_pkg::CountWidth-1:0]  cycle_count,
	output logic                            empty,
	input  logic                            pop,
	output logic [cce_pkg::TotalWidth-1:0]  time_us,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cce_pkg::DivWidth-1:0]    cfg_data
);

	cce_pkg::rd_req_t front_req;
	cce_pkg::rd_req_t head_req;
	logic             accept;
	logic             req_pop;

	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	cce_front #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.cycle_count(cycle_count),
		.req        (front_req)
	);

	cce_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_req(front_req),
		.rd_pop(req_pop),
		.full  (full),
		.rd_req(head_req)
	);

	cce_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.req     (head_req),
		.req_pop (req_pop),
		.pop     (pop),
		.empty   (empty),
		.time_us (time_us)
	);

endmodule

// File: verif/testbench.sv
// Testbench for the cycle counter extension: wrap tracking and microsecond reads checked on the fly.
`timescale 1ns / 1ps

module testbench;

	localparam int CounterBits   = 32;
	localparam int Latency       = 80;
	localparam int WatchdogLimit = 4000;
	localparam int RandomItems   = 1050;
	localparam int Phases        = 7;
	localparam logic [cce_pkg::CountWidth-1:0] SampleMask =
		cce_pkg::CountWidth'((64'd1 << CounterBits) - 1);

	logic                           clk;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic                           op;
	logic [cce_pkg::CountWidth-1:0] cycle_count;
	logic                           empty;
	logic                           pop = 1'b0;
	logic [cce_pkg::TotalWidth-1:0] time_us;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [cce_pkg::DivWidth-1:0]   cfg_data;

	// Shadow of the block's state and register
	logic [31:0]                    wraps_seen  = '0;
	logic [cce_pkg::CountWidth-1:0] last_sample = '0;
	logic [cce_pkg::DivWidth-1:0]   us_divisor  = cce_pkg::DivOne;
	logic [cce_pkg::TotalWidth-1:0] time_expected[$];

	int mismatches    = 0;
	int items_sent    = 0;
	int reads_checked = 0;
	int wrap_events   = 0;
	int settings_used = 0;
	int stall_left    = 0;
	int idle_cycles   = 0;
	bit quiet         = 1'b0;
	logic [cce_pkg::CountWidth-1:0] counter_now = '0;
	logic [cce_pkg::CountWidth-1:0] masked;

	cycle_counter_extend_to_us_top #(
		.COUNTER_BITS(CounterBits)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.cycle_count(cycle_count),
		.empty      (empty),
		.pop        (pop),
		.time_us    (time_us),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Extended cycle total divided by cycles per microsecond; zero divides as one
	function automatic logic [cce_pkg::TotalWidth-1:0] us_from_count(input logic [31:0] wraps,
			input logic [cce_pkg::CountWidth-1:0] sample,
			input logic [cce_pkg::DivWidth-1:0] div);
		logic [cce_pkg::TotalWidth-1:0] total;
		logic [cce_pkg::TotalWidth-1:0] denom;
		total = ({32'b0, wraps} << CounterBits) + cce_pkg::TotalWidth'(sample);
		denom = (div == '0) ? cce_pkg::TotalWidth'(1) : cce_pkg::TotalWidth'(div);
		return total / denom;
	endfunction

	// Present one word, with an occasional gap first, and hold until taken
	task automatic send_word(input logic word_op,
			input logic [cce_pkg::CountWidth-1:0] word_count);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		op          <= word_op;
		cycle_count <= word_count;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// Drop push, wait for every expected time, then let the divider go quiet
	task automatic settle();
		push <= 1'b0;
		while (time_expected.size() != 0) @(posedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	// Write cycles_per_us; only called while the block is idle
	task automatic write_divisor(input logic [cce_pkg::DivWidth-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Reads right after reset with the default divisor, equal samples
	task automatic test_reset_state();
		send_word(cce_pkg::OP_READ, '0);
		send_word(cce_pkg::OP_SAMPLE, 32'hFFFF_FFFF);
		send_word(cce_pkg::OP_READ, 32'hFFFF_FFFF);
		settle();
	endtask

	// Wraps, equal samples, big jumps that hide several wraps
	task automatic test_wraps();
		send_word(cce_pkg::OP_READ, 32'h0000_0000);
		send_word(cce_pkg::OP_SAMPLE, 32'h8000_0000);
		send_word(cce_pkg::OP_READ, 32'h7FFF_FFFF);
		send_word(cce_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
		send_word(cce_pkg::OP_READ, 32'h0000_0001);
		send_word(cce_pkg::OP_READ, 32'hAAAA_5555);
		send_word(cce_pkg::OP_SAMPLE, 32'h5555_AAAA);
		send_word(cce_pkg::OP_READ, 32'h5555_AAAB);
		settle();
	endtask

	// Zero divisor, divisors above range, extremes of the register
	task automatic test_divisors();
		logic [cce_pkg::DivWidth-1:0] picks[6];
		picks = '{13'd0, 13'd8191, 13'd4295, 13'd4294, 13'd3, 13'd1};
		foreach (picks[i]) begin
			write_divisor(picks[i]);
			send_word(cce_pkg::OP_READ, 32'hFFFF_FFFF - 32'(i));
			settle();
		end
	endtask

	// Mostly a counter running forward at random speeds, some noise samples
	task automatic test_random_counter();
		int kind;
		for (int phase = 0; phase < Phases; phase++) begin
			if (phase == Phases - 1) quiet = 1'b1;
			case (phase)
				0: ;
				1: write_divisor(13'd4294);
				2: write_divisor(13'd0);
				3: write_divisor(13'd8191);
				5: write_divisor(cce_pkg::DivWidth'($urandom()));
				default: write_divisor(cce_pkg::DivWidth'($urandom_range(1, 4294)));
			endcase
			repeat (RandomItems / Phases) begin
				kind = $urandom_range(0, 99);
				if (kind < 45) counter_now += $urandom_range(0, 1000);
				else if (kind < 70) counter_now += $urandom_range(0, 1 << 24);
				else if (kind < 85) counter_now += $urandom();
				else counter_now = $urandom();
				send_word(($urandom_range(0, 9) < 4) ? cce_pkg::OP_READ : cce_pkg::OP_SAMPLE,
					counter_now);
			end
			settle();
		end
	endtask

	// Result side: pop with random stall bursts, none in the quiet part
	always @(posedge clk) begin
		if (quiet) begin
			pop <= 1'b1;
		end else if (stall_left > 0) begin
			pop        <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			pop        <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			pop <= 1'b1;
		end
	end

	// Track register writes, predict on each taken word, check each popped word
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) us_divisor = cfg_data;

			if (pop && !empty) begin
				if (time_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: time_us %0d with none expected", time_us);
				end else begin
					if (time_us !== time_expected[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: time_us expected %0d got %0d",
								time_expected[0], time_us);
					end
					void'(time_expected.pop_front());
					reads_checked++;
				end
			end

			if (push && !full) begin
				masked = cycle_count & SampleMask;
				if (masked < last_sample) begin
					wraps_seen = wraps_seen + 1;
					wrap_events++;
				end
				last_sample = masked;
				if (op == cce_pkg::OP_READ)
					time_expected.push_back(us_from_count(wraps_seen, masked, us_divisor));
			end

			// Hold off a hang: count cycles with no word moving anywhere
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchdogLimit) begin
				$display("watchdog expired with %0d times pending", time_expected.size());
				$display("cycle_counter_extend_to_us_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		op          = cce_pkg::OP_SAMPLE;
		cycle_count = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_wraps();
		test_divisors();
		test_random_counter();

		$display("sent %0d words, checked %0d reads, %0d wraps seen",
			items_sent, reads_checked, wrap_events);
		$display("%0d divisor settings applied, %0d mismatches", settings_used, mismatches);
		if (mismatches == 0 && time_expected.size() == 0) begin
			$display("cycle_counter_extend_to_us_top: match");
		end else begin
			$display("cycle_counter_extend_to_us_top: mismatch");
		end
		$finish;
	end

endmodule
